// File: design/aspect_ratio_reduce_defines.svh
// assertion macros used by the checker file arr_checker.sv
// no dependencies
`ifndef ASPECT_RATIO_REDUCE_DEFINES_SVH
`define ASPECT_RATIO_REDUCE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ARR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("aspect_ratio_reduce: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ARR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("aspect_ratio_reduce: next-cycle check failed");

`endif

// File: design/arr_pkg.sv
// shared types and sequencer codes for aspect_ratio_reduce
// no dependencies
package arr_pkg;

	typedef struct packed {
		logic busy;
		logic done;
	} arr_div_stat_t;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_GCD  = 3'd2;
	localparam logic [2:0] ST_DIVW = 3'd3;
	localparam logic [2:0] ST_DIVH = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

endpackage

// File: design/aspect_ratio_reduce.sv
// Reduces a width and height to their simplest ratio by Euclid's method. A word
// with a negative dimension, or with both dimensions zero, gives ratio_valid low
// and both ratio fields zero without any divider pass. Otherwise every Euclid
// remainder and both final quotients run on one restoring divider that retires
// one bit a cycle while busy; the sequencer takes each result when the divider
// flags done. At 16 bits a word takes at most 22 remainder steps. One word is in
// work at a time; a finished result waits in the output register while the next
// word is taken in.
// depends on arr_pkg and arr_div
module aspect_ratio_reduce import arr_pkg::*; #(
	parameter int DIM_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DIM_BITS-1:0] width,
	input  logic [DIM_BITS-1:0] height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIM_BITS-2:0] ratio_width,
	output logic [DIM_BITS-2:0] ratio_height,
	output logic                ratio_valid
);

	localparam int VAL_BITS = DIM_BITS - 1;

	logic [2:0]          state_q;
	logic [VAL_BITS-1:0] w_q;
	logic [VAL_BITS-1:0] h_q;
	logic [VAL_BITS-1:0] a_q;
	logic [VAL_BITS-1:0] b_q;
	logic [VAL_BITS-1:0] res_w_q;
	logic [VAL_BITS-1:0] res_h_q;
	logic                res_v_q;
	logic                out_valid_q;
	logic [VAL_BITS-1:0] ratio_width_q;
	logic [VAL_BITS-1:0] ratio_height_q;
	logic                ratio_valid_q;

	logic                in_bad;
	logic                out_free;
	logic                div_go;
	logic                div_start;
	logic [VAL_BITS-1:0] div_dividend;
	logic [VAL_BITS-1:0] div_divisor;
	arr_div_stat_t       div_stat;
	logic [VAL_BITS-1:0] div_quot;
	logic [VAL_BITS-1:0] div_rem;

	arr_div #(
		.VAL_BITS(VAL_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.stat    (div_stat),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_bad    = width[DIM_BITS-1] || height[DIM_BITS-1] ||
	                   ((width == '0) && (height == '0));
	assign out_free  = !out_valid_q || out_ready;
	assign div_start = div_go && !div_stat.busy;

	// divider operand select per sequencer step
	always_comb begin
		div_go       = 1'b0;
		div_dividend = a_q;
		div_divisor  = b_q;
		unique case (state_q)
			ST_CHK: begin
				div_go = 1'b1;
				if (b_q == '0) begin
					div_dividend = w_q;
					div_divisor  = a_q;
				end
			end
			ST_DIVW: begin
				div_go       = div_stat.done;
				div_dividend = h_q;
				div_divisor  = a_q;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= in_bad ? ST_DONE : ST_CHK;
					end
				end
				ST_CHK: begin
					if (div_start) begin
						state_q <= (b_q == '0) ? ST_DIVW : ST_GCD;
					end
				end
				ST_GCD: begin
					if (div_stat.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_DIVW: begin
					if (div_start) begin
						state_q <= ST_DIVH;
					end
				end
				ST_DIVH: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				w_q     <= width[VAL_BITS-1:0];
				h_q     <= height[VAL_BITS-1:0];
				a_q     <= width[VAL_BITS-1:0];
				b_q     <= height[VAL_BITS-1:0];
				res_w_q <= '0;
				res_h_q <= '0;
				res_v_q <= 1'b0;
			end
			ST_GCD: begin
				if (div_stat.done) begin
					a_q <= b_q;
					b_q <= div_rem;
				end
			end
			ST_DIVW: begin
				if (div_stat.done) begin
					res_w_q <= div_quot;
				end
			end
			ST_DIVH: begin
				if (div_stat.done) begin
					res_h_q <= div_quot;
					res_v_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ratio_width_q  <= res_w_q;
					ratio_height_q <= res_h_q;
					ratio_valid_q  <= res_v_q;
				end
			end
			default: begin
				res_v_q <= res_v_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign ratio_width  = ratio_width_q;
	assign ratio_height = ratio_height_q;
	assign ratio_valid  = ratio_valid_q;

endmodule

// File: design/arr_div.sv
// shared restoring divider, one quotient bit per cycle while busy
// depends on arr_pkg
module arr_div import arr_pkg::*; #(
	parameter int VAL_BITS = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [VAL_BITS-1:0] dividend,
	input  logic [VAL_BITS-1:0] divisor,
	output arr_div_stat_t       stat,
	output logic [VAL_BITS-1:0] quot,
	output logic [VAL_BITS-1:0] rem
);

	localparam int CNT_BITS = $clog2(VAL_BITS + 1);
	localparam logic [CNT_BITS-1:0] CNT_START = CNT_BITS'(VAL_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [VAL_BITS-1:0] rem_q;
	logic [VAL_BITS-1:0] quo_q;
	logic [VAL_BITS-1:0] dsr_q;
	logic [VAL_BITS:0]   partial;
	logic [VAL_BITS:0]   diff;

	assign partial = {rem_q, quo_q[VAL_BITS-1]};
	assign diff    = partial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				cnt_q  <= CNT_START;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_LAST;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VAL_BITS]) begin
				rem_q <= diff[VAL_BITS-1:0];
				quo_q <= {quo_q[VAL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= partial[VAL_BITS-1:0];
				quo_q <= {quo_q[VAL_BITS-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;
	assign rem       = rem_q;

endmodule

// File: design/arr_checker.sv
// port-level checks for aspect_ratio_reduce, bound to the top level
// depends on aspect_ratio_reduce_defines.svh
`include "aspect_ratio_reduce_defines.svh"

module arr_checker #(
	parameter int DIM_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [DIM_BITS-2:0] ratio_width,
	input logic [DIM_BITS-2:0] ratio_height,
	input logic                ratio_valid
);

	// a stalled result word holds
	`ARR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(ratio_width) && $stable(ratio_height) && $stable(ratio_valid))

	// an invalid result carries zero ratios
	`ARR_ASSERT_SAME(a_bad_zero, clk, arst_n, out_valid && !ratio_valid, (ratio_width == '0) && (ratio_height == '0))

	// a valid ratio is never zero by zero
	`ARR_ASSERT_SAME(a_good_nonzero, clk, arst_n, out_valid && ratio_valid, (ratio_width != '0) || (ratio_height != '0))

	// after taking a word the block is not ready in the next cycle
	`ARR_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind aspect_ratio_reduce arr_checker #(
	.DIM_BITS(DIM_BITS)
) u_arr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.ratio_width (ratio_width),
	.ratio_height(ratio_height),
	.ratio_valid (ratio_valid)
);

// File: bench/testbench.sv
// testbench for aspect_ratio_reduce: drives width/height words, predicts each reduced ratio
// with its own euclid model and checks every result word in order
// depends on the aspect_ratio_reduce rtl only
`timescale 1ns / 100ps

module testbench;

	localparam int DIM_BITS = 16;
	localparam int LIMIT_NS = 20_000_000;

	typedef logic [DIM_BITS-1:0] dim_t;

	typedef struct packed {
		logic [DIM_BITS-2:0] rw;
		logic [DIM_BITS-2:0] rh;
		logic                ok;
	} ratio_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	dim_t                width = '0;
	dim_t                height = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DIM_BITS-2:0] ratio_width;
	logic [DIM_BITS-2:0] ratio_height;
	logic                ratio_valid;

	ratio_t      ratio_q[$];
	int          mismatch_count = 0;
	int          burst_left = 0;
	bit          idle_on = 1'b0;
	logic [15:0] stall_pat = 16'hffff;
	logic [5:0]  stall_tick = '0;

	aspect_ratio_reduce #(.DIM_BITS(DIM_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.width(width),
		.height(height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ratio_width(ratio_width),
		.ratio_height(ratio_height),
		.ratio_valid(ratio_valid)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic ratio_t reduce_ratio(input dim_t w, input dim_t h);
		dim_t   a;
		dim_t   b;
		dim_t   r;
		ratio_t res;
		res = '0;
		if (w[DIM_BITS-1] || h[DIM_BITS-1] || (w == '0 && h == '0))
			return res;
		a = w;
		b = h;
		while (b != '0) begin
			r = a % b;
			a = b;
			b = r;
		end
		res.rw = (DIM_BITS-1)'(w / a);
		res.rh = (DIM_BITS-1)'(h / a);
		res.ok = 1'b1;
		return res;
	endfunction

	// receiver stall pattern, reloaded whenever stall_tick wraps to zero
	always @(posedge clk) begin
		if (stall_tick == '0)
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
		out_ready <= idle_on ? stall_pat[stall_tick[3:0]] : 1'b1;
		stall_tick = stall_tick + 1'b1;
	end

	// handshake values are stable by the falling edge
	always @(negedge clk) begin : check_ratio
		ratio_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ratio_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result word %0d:%0d valid %b", $realtime,
						ratio_width, ratio_height, ratio_valid);
			end else begin
				want = ratio_q.pop_front();
				if (ratio_width !== want.rw || ratio_height !== want.rh ||
						ratio_valid !== want.ok) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: expected %0d:%0d valid %b, got %0d:%0d valid %b",
							$realtime, want.rw, want.rh, want.ok,
							ratio_width, ratio_height, ratio_valid);
				end
			end
		end
	end

	task automatic send_word(input dim_t w, input dim_t h);
		int gap;
		bit taken;
		if (idle_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 450)
					: $urandom_range(0, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		width <= w;
		height <= h;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			if (taken)
				ratio_q.push_back(reduce_ratio(w, h));
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (ratio_q.size() != 0);
	endtask

	task automatic test_corner_sizes();
		send_word(16'd1, 16'd1);
		send_word(16'd32767, 16'd32767);
		send_word(16'd32767, 16'd1);
		send_word(16'd1, 16'd32767);
		send_word(16'd1920, 16'd1080);
		send_word(16'd4096, 16'd2048);
		send_word(16'd30000, 16'd20000);
		send_word(16'd32767, 16'd32766);
	endtask

	task automatic test_unknown_sizes();
		send_word(16'd0, 16'd0);
		send_word(16'hffff, 16'd5);
		send_word(16'd5, 16'hffff);
		send_word(16'h8000, 16'h8000);
		send_word(16'hffff, 16'hffff);
		send_word(16'h8000, 16'd0);
		send_word(16'd0, 16'hffff);
	endtask

	task automatic test_zero_dims();
		send_word(16'd0, 16'd7);
		send_word(16'd9, 16'd0);
		send_word(16'd0, 16'd32767);
		send_word(16'd32767, 16'd0);
	endtask

	// consecutive fibonacci numbers give the longest remainder chain
	task automatic test_long_euclid();
		send_word(16'd28657, 16'd17711);
		send_word(16'd17711, 16'd28657);
	endtask

	task automatic test_drain_pause();
		send_word(16'd640, 16'd480);
		send_word(16'd28657, 16'd46);
		wait_drained();
		send_word(16'd1280, 16'd1024);
		send_word(16'd2, 16'd4);
	endtask

	task automatic test_random(input int count);
		dim_t w;
		dim_t h;
		int   g;
		int   m;
		repeat (count) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
					g = $urandom_range(1, 1024);
					m = 32767 / g;
					w = dim_t'($urandom_range(0, m) * g);
					h = dim_t'($urandom_range(0, m) * g);
				end
				11, 12, 13: begin
					w = 16'($urandom);
					h = 16'($urandom);
					if ($urandom_range(0, 1))
						w[DIM_BITS-1] = 1'b1;
					else
						h[DIM_BITS-1] = 1'b1;
				end
				14, 15: begin
					w = dim_t'($urandom_range(0, 15));
					h = dim_t'($urandom_range(0, 15));
				end
				default: begin
					w = 16'($urandom);
					h = 16'($urandom);
				end
			endcase
			send_word(w, h);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b0;
		test_corner_sizes();
		test_unknown_sizes();
		idle_on = 1'b1;
		test_zero_dims();
		test_long_euclid();
		test_drain_pause();
		test_random(430);
		wait_drained();
		repeat (500) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
